### hdl/gsa_pkg.sv
package gsa_pkg;

   // Fixed field widths of the channels
   localparam int INDEX_W  = 32;
   localparam int SAMPLE_W = 32;
   localparam int RESULT_W = 48;
   localparam int EMIT_W   = 16;
   localparam int MODE_W   = 2;
   localparam int LIMIT_W  = 16;

   // Configuration register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LIMIT_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_AGGREGATE_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISSING_LIMIT  = 1'b1;

   // Aggregation modes
   localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LAST = 2'd3;

   // Close-command queue depth (power of two, at least two)
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [MODE_W-1:0]  aggregate_mode;
      logic [LIMIT_W-1:0] missing_limit;
   } gsa_cfg_type;

endpackage

### hdl/gsa_req_if.sv
interface gsa_req_if import gsa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [INDEX_W-1:0]         group_index;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic                       sample_missing;
   logic                       series_first;
   logic                       series_last;

   modport source (
      output valid, group_index, sample_value, sample_missing, series_first, series_last,
      input  ready
   );
   modport sink (
      input  valid, group_index, sample_value, sample_missing, series_first, series_last,
      output ready
   );
endinterface

### hdl/gsa_rsp_if.sv
interface gsa_rsp_if import gsa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] result_value;
   logic                       result_missing;
   logic [INDEX_W-1:0]         closed_group;
   logic [EMIT_W-1:0]          groups_emitted;
   logic                       result_status;
   logic                       end_of_series;

   modport source (
      output valid, result_value, result_missing, closed_group, groups_emitted,
             result_status, end_of_series,
      input  ready
   );
   modport sink (
      input  valid, result_value, result_missing, closed_group, groups_emitted,
             result_status, end_of_series,
      output ready
   );
endinterface

### hdl/gsa_front.sv
module gsa_front import gsa_pkg::*; #(
   parameter int ACC_BITS   = 48,
   parameter int COUNT_BITS = 16,
   localparam int CMD_W     = ACC_BITS + 2 * COUNT_BITS + INDEX_W + 4
) (
   input  logic              clock,
   input  logic              reset,
   gsa_req_if.sink           req,
   input  gsa_cfg_type       cfg,
   input  logic              queue_room,
   output logic              push_first,
   output logic              push_second,
   output logic [CMD_W-1:0]  push_data_first,
   output logic [CMD_W-1:0]  push_data_second
);

   localparam int CMP_W = 32;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] value;
      logic [COUNT_BITS-1:0]      divisor;
      logic                       do_div;
      logic                       missing;
      logic [INDEX_W-1:0]         closed_group;
      logic [COUNT_BITS-1:0]      emitted;
      logic                       status;
      logic                       eos;
   } cmd_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == '1) ? c : c + COUNT_BITS'(1);
   endfunction

   // Build a close command for one group
   function automatic cmd_type make_cmd(
      input logic signed [ACC_BITS-1:0] agg,
      input logic [COUNT_BITS-1:0]      pc,
      input logic [COUNT_BITS-1:0]      mc,
      input logic [INDEX_W-1:0]         grp,
      input logic [COUNT_BITS-1:0]      em,
      input logic                       eos,
      input gsa_cfg_type                c
   );
      cmd_type r;
      r.missing      = CMP_W'(mc) > CMP_W'(c.missing_limit);
      r.value        = r.missing ? '0 : agg;
      r.divisor      = pc;
      r.do_div       = (c.aggregate_mode == MODE_MEAN) && (pc != '0) && !r.missing;
      r.closed_group = grp;
      r.emitted      = em;
      r.status       = 1'b0;
      r.eos          = eos;
      return r;
   endfunction

   // Series state
   logic signed [ACC_BITS-1:0] agg_ff, agg_in;
   logic [COUNT_BITS-1:0]      pc_ff, pc_in, mc_ff, mc_in, em_ff, em_in;
   logic [INDEX_W-1:0]         prev_ff, prev_in;
   logic                       err_ff, err_in, open_ff, open_in;

   logic                       accept;
   logic signed [ACC_BITS-1:0] agg0, agg1, agg2, v;
   logic signed [ACC_BITS:0]   sum;
   logic [COUNT_BITS-1:0]      pc0, mc0, em0, pc1, mc1, em1, pc2, mc2, em3;
   logic [INDEX_W-1:0]         prev0;
   logic                       err0, open0, is_err, close_a;
   cmd_type                    cmd_a, cmd_b, cmd_err;

   assign req.ready = queue_room;
   assign accept    = req.valid && queue_room;

   always_comb begin
      // series_first clears everything before the item is looked at
      agg0  = req.series_first ? '0 : agg_ff;
      pc0   = req.series_first ? '0 : pc_ff;
      mc0   = req.series_first ? '0 : mc_ff;
      em0   = req.series_first ? '0 : em_ff;
      err0  = req.series_first ? 1'b0 : err_ff;
      open0 = req.series_first ? 1'b0 : open_ff;
      prev0 = req.series_first ? req.group_index : prev_ff;

      is_err  = open0 && (req.group_index < prev0);
      close_a = open0 && (req.group_index != prev0) && !is_err;

      // group left behind by an index change
      agg1 = close_a ? '0 : agg0;
      pc1  = close_a ? '0 : pc0;
      mc1  = close_a ? '0 : mc0;
      em1  = close_a ? sat_inc(em0) : em0;

      // fold in the sample
      v   = req.sample_missing ? '0 : ACC_BITS'(req.sample_value);
      pc2 = req.sample_missing ? pc1 : sat_inc(pc1);
      mc2 = req.sample_missing ? sat_inc(mc1) : mc1;
      sum = (ACC_BITS + 1)'(agg1) + (ACC_BITS + 1)'(v);
      case (cfg.aggregate_mode)
         MODE_SUM, MODE_MEAN: begin
            if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
               agg2 = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                    : {1'b0, {(ACC_BITS-1){1'b1}}};
            end else begin
               agg2 = sum[ACC_BITS-1:0];
            end
         end
         MODE_MAX: agg2 = (v > agg1) ? v : agg1;
         default:  agg2 = v;
      endcase
      em3 = sat_inc(em1);

      cmd_a = make_cmd(agg0, pc0, mc0, prev0, em1, 1'b0, cfg);
      cmd_b = make_cmd(agg2, pc2, mc2, req.group_index, em3, req.series_last, cfg);

      cmd_err              = '0;
      cmd_err.closed_group = prev0;
      cmd_err.emitted      = em0;
      cmd_err.status       = 1'b1;
      cmd_err.eos          = req.series_last;

      // next state
      agg_in  = agg_ff;
      pc_in   = pc_ff;
      mc_in   = mc_ff;
      em_in   = em_ff;
      err_in  = err_ff;
      open_in = open_ff;
      prev_in = prev_ff;
      if (accept) begin
         agg_in  = agg0;
         pc_in   = pc0;
         mc_in   = mc0;
         em_in   = em0;
         err_in  = err0;
         open_in = open0;
         prev_in = prev0;
         if (!err0) begin
            if (is_err) begin
               err_in  = 1'b1;
               agg_in  = '0;
               pc_in   = '0;
               mc_in   = '0;
               open_in = 1'b0;
            end else begin
               prev_in = req.group_index;
               if (req.series_last) begin
                  agg_in  = '0;
                  pc_in   = '0;
                  mc_in   = '0;
                  open_in = 1'b0;
                  em_in   = '0;
               end else begin
                  agg_in  = agg2;
                  pc_in   = pc2;
                  mc_in   = mc2;
                  open_in = 1'b1;
                  em_in   = em1;
               end
            end
         end
      end
   end

   // Queue pushes: at most two close commands per beat
   assign push_first  = accept && !err0 && (is_err || close_a || req.series_last);
   assign push_second = accept && !err0 && !is_err && close_a && req.series_last;
   assign push_data_first  = is_err ? cmd_err : (close_a ? cmd_a : cmd_b);
   assign push_data_second = cmd_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         agg_ff  <= '0;
         pc_ff   <= '0;
         mc_ff   <= '0;
         em_ff   <= '0;
         err_ff  <= 1'b0;
         open_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         agg_ff  <= agg_in;
         pc_ff   <= pc_in;
         mc_ff   <= mc_in;
         em_ff   <= em_in;
         err_ff  <= err_in;
         open_ff <= open_in;
         prev_ff <= prev_in;
      end
   end

endmodule

### hdl/gsa_queue.sv
module gsa_queue import gsa_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_first,
   input  logic              push_second,
   input  logic [WIDTH-1:0]  push_data_first,
   input  logic [WIDTH-1:0]  push_data_second,
   input  logic              pop,
   output logic [WIDTH-1:0]  head,
   output logic              not_empty,
   output logic              room
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [PTR_W:0]   count_ff, count_in;

   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign head      = store_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   // room for the two commands a single beat can produce
   assign room      = count_ff <= (PTR_W + 1)'(QUEUE_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_first) + PTR_W'(push_second);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + (PTR_W + 1)'(push_first) + (PTR_W + 1)'(push_second)
                  - (PTR_W + 1)'(pop);
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_first) begin
         store_ff[wr_ptr_ff] <= push_data_first;
      end
      if (push_second) begin
         store_ff[wr_next] <= push_data_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/gsa_back.sv
module gsa_back import gsa_pkg::*; #(
   parameter int ACC_BITS   = 48,
   parameter int COUNT_BITS = 16,
   localparam int CMD_W     = ACC_BITS + 2 * COUNT_BITS + INDEX_W + 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CMD_W-1:0]  head,
   input  logic              not_empty,
   output logic              pop,
   gsa_rsp_if.source         rsp
);

   localparam int STEP_W = $clog2(ACC_BITS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] value;
      logic [COUNT_BITS-1:0]      divisor;
      logic                       do_div;
      logic                       missing;
      logic [INDEX_W-1:0]         closed_group;
      logic [COUNT_BITS-1:0]      emitted;
      logic                       status;
      logic                       eos;
   } cmd_type;

   cmd_type                    head_cmd, cmd_ff, cmd_in;
   logic [1:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [ACC_BITS-1:0]        quo_ff, quo_in;
   logic [COUNT_BITS:0]        rem_ff, rem_in, rem_shift;
   logic                       neg_ff, neg_in, ge;
   logic signed [ACC_BITS-1:0] quo_val;

   // Output register
   logic                       out_valid_ff, out_valid_in, out_free, load;
   logic signed [RESULT_W-1:0] value_ff, value_in;
   logic                       missing_ff, missing_in, status_ff, status_in, eos_ff, eos_in;
   logic [INDEX_W-1:0]         group_ff, group_in;
   logic [EMIT_W-1:0]          emitted_ff, emitted_in;

   assign head_cmd = cmd_type'(head);
   assign out_free = !out_valid_ff || rsp.ready;

   // One restoring-division step per cycle
   assign rem_shift = {rem_ff[COUNT_BITS-1:0], quo_ff[ACC_BITS-1]};
   assign ge        = rem_shift >= {1'b0, cmd_ff.divisor};
   assign quo_val   = neg_ff ? ACC_BITS'(-quo_ff) : quo_ff;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      cmd_in     = cmd_ff;
      pop        = 1'b0;
      load       = 1'b0;
      value_in   = value_ff;
      missing_in = missing_ff;
      group_in   = group_ff;
      emitted_in = emitted_ff;
      status_in  = status_ff;
      eos_in     = eos_ff;
      case (state_ff)
         S_IDLE: begin
            if (not_empty && head_cmd.do_div) begin
               pop      = 1'b1;
               cmd_in   = head_cmd;
               neg_in   = head_cmd.value[ACC_BITS-1];
               quo_in   = head_cmd.value[ACC_BITS-1] ? ACC_BITS'(-head_cmd.value)
                                                    : head_cmd.value;
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DIV;
            end else if (not_empty && out_free) begin
               pop        = 1'b1;
               load       = 1'b1;
               value_in   = RESULT_W'(head_cmd.value);
               missing_in = head_cmd.missing;
               group_in   = head_cmd.closed_group;
               emitted_in = EMIT_W'(head_cmd.emitted);
               status_in  = head_cmd.status;
               eos_in     = head_cmd.eos;
            end
         end
         S_DIV: begin
            rem_in  = ge ? rem_shift - {1'b0, cmd_ff.divisor} : rem_shift;
            quo_in  = {quo_ff[ACC_BITS-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ACC_BITS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load       = 1'b1;
               value_in   = RESULT_W'(quo_val);
               missing_in = cmd_ff.missing;
               group_in   = cmd_ff.closed_group;
               emitted_in = EMIT_W'(cmd_ff.emitted);
               status_in  = cmd_ff.status;
               eos_in     = cmd_ff.eos;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      missing_ff <= missing_in;
      group_ff   <= group_in;
      emitted_ff <= emitted_in;
      status_ff  <= status_in;
      eos_ff     <= eos_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.result_value   = value_ff;
   assign rsp.result_missing = missing_ff;
   assign rsp.closed_group   = group_ff;
   assign rsp.groups_emitted = emitted_ff;
   assign rsp.result_status  = status_ff;
   assign rsp.end_of_series  = eos_ff;

endmodule

### hdl/grouped_series_aggregator.sv
// Grouped series aggregator. Each req beat carries one Q16.16 sample with its group
// index and missing/first/last marks; each rsp beat is one closed group (sum, mean,
// maximum from zero or last value, chosen by the aggregate_mode register). The front
// end takes one sample per cycle while ready, folding it into the running aggregate;
// closing a group pushes a command into a four-entry queue, which the back end turns
// into a result. Sum, maximum, last-value and error results load the output register
// directly; a mean result with a nonzero sample count that is not missing first
// runs through the one-bit-per-cycle restoring divider. req_ch.ready drops while
// the queue has fewer than two free entries, so a long run of short mean groups is
// paced by the divider. Write the csr registers only while no beat is in flight.
module grouped_series_aggregator import gsa_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int ACC_BITS   = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   gsa_req_if.sink                 req_ch,
   gsa_rsp_if.source               rsp_ch,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   localparam int CMD_W = ACC_BITS + 2 * COUNT_BITS + INDEX_W + 4;

   gsa_cfg_type      cfg_ff, cfg_in;
   logic             push_first, push_second, pop, not_empty, room;
   logic [CMD_W-1:0] push_data_first, push_data_second, head;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_AGGREGATE_MODE: cfg_in.aggregate_mode = csr_write_data[MODE_W-1:0];
            CSR_MISSING_LIMIT:  cfg_in.missing_limit  = csr_write_data[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gsa_front #(
      .ACC_BITS   (ACC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .cfg              (cfg_ff),
      .queue_room       (room),
      .push_first       (push_first),
      .push_second      (push_second),
      .push_data_first  (push_data_first),
      .push_data_second (push_data_second)
   );

   gsa_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock            (clock),
      .reset            (reset),
      .push_first       (push_first),
      .push_second      (push_second),
      .push_data_first  (push_data_first),
      .push_data_second (push_data_second),
      .pop              (pop),
      .head             (head),
      .not_empty        (not_empty),
      .room             (room)
   );

   gsa_back #(
      .ACC_BITS   (ACC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

endmodule
